### sv/vlan_learning_bridge_assert.svh
// Assertion macros shared by the bridge checker
`ifndef VLAN_LEARNING_BRIDGE_ASSERT_SVH
`define VLAN_LEARNING_BRIDGE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define VLB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define VLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/vlb_pkg.sv
// Types and constants of the VLAN learning bridge
`default_nettype none
package vlb_pkg;

  localparam int VLAN_W = 12;
  localparam int MAC_W  = 48;
  localparam int CFG_PORTS = 4;

  typedef enum logic [1:0] {
    VERDICT_UNICAST = 2'd0,
    VERDICT_FLOOD   = 2'd1,
    VERDICT_DROP    = 2'd2,
    VERDICT_FILTER  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    REG_TRUNK  = 2'd0,
    REG_ACCESS = 2'd1,
    REG_NATIVE = 2'd2,
    REG_LINK   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_OUT    = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]        ingress_port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic              has_tag;
    logic [VLAN_W-1:0] tag_vlan;
  } in_word_t;

  typedef struct packed {
    logic [3:0]        egress_mask;
    logic [3:0]        tagged_mask;
    logic [VLAN_W-1:0] egress_vlan;
    verdict_t          verdict;
  } out_word_t;

  // Search key held while a lookup walks the chain
  typedef struct packed {
    logic [VLAN_W-1:0] vlan;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [1:0]        port;
  } key_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic       active;
    logic       src_hit;
    logic       dst_hit;
    logic       dst_victim;
    logic [1:0] dst_port;
  } chain_t;

endpackage
`default_nettype wire

### sv/vlan_learning_bridge.sv
// Top level of the VLAN learning bridge
//
//  channel | signals                      | direction
//  --------+------------------------------+----------
//  input   | in_valid in_ready in_data    | into block
//  output  | out_valid out_ready out_data | out of block
//  config  | cfg_valid cfg_ready cfg_addr | into block
//          | cfg_data                     |
//
// For a classified frame the lookup token, launched from the start register,
// walks the chain of table cells one cell per clock; the tail loads the result.
// A frame dropped by VLAN shows its result the cycle after acceptance.
// One word is in flight at a time; in_ready rises again once the result is taken.
// Reset (rst, synchronous) invalidates every table entry at once.
`default_nettype none
module vlan_learning_bridge import vlb_pkg::*; #(
  parameter int PORTS         = 4,
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [47:0] cfg_data
);

  localparam int NP   = (PORTS < CFG_PORTS) ? PORTS : CFG_PORTS;
  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam logic [2:0]    NP3  = 3'(NP);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [3:0]          trunk_port_mask;
  logic [47:0]         access_vlans;
  logic [47:0]         native_vlans;
  logic [3:0]          link_up_mask;
  logic [AW-1:0]       replace_pointer;
  key_t                key;
  out_word_t           result;
  out_word_t           drop_word;
  out_word_t           done_word;
  logic [VLAN_W-1:0]   class_vlan;
  logic [VLAN_W-1:0]   acc_in;
  logic                start;
  logic                insert;
  logic                take;
  chain_t              links [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] victim;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trunk_port_mask <= 4'h0;
      access_vlans    <= 48'h0010_0100_1001;
      native_vlans    <= 48'h0010_0100_1001;
      link_up_mask    <= 4'hf;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_TRUNK:  trunk_port_mask <= cfg_data[3:0];
        REG_ACCESS: access_vlans    <= cfg_data;
        REG_NATIVE: native_vlans    <= cfg_data;
        REG_LINK:   link_up_mask    <= cfg_data[3:0];
        default:    ;
      endcase
    end
  end

  // Classify the ingress VLAN
  assign acc_in = access_vlans[12*in_data.ingress_port +: 12];

  always_comb begin
    class_vlan = '0;
    if ({1'b0, in_data.ingress_port} < NP3) begin
      if (!trunk_port_mask[in_data.ingress_port]) begin
        if (!in_data.has_tag || in_data.tag_vlan == acc_in) begin
          class_vlan = acc_in;
        end
      end else begin
        class_vlan = in_data.has_tag ? in_data.tag_vlan
                                     : native_vlans[12*in_data.ingress_port +: 12];
      end
    end
  end

  assign take = in_valid && in_ready;

  // Hold the key for the walk
  always_ff @(posedge clk) begin
    if (take) begin
      key.vlan <= class_vlan;
      key.src  <= in_data.src_mac;
      key.dst  <= in_data.dst_mac;
      key.port <= in_data.ingress_port;
    end
  end

  // Launch the token once the key is held
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= take && (class_vlan != '0);
    end
  end

  // Chain of table cells
  always_comb begin
    links[0] = '0;
    links[0].active = start;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign victim[i] = (replace_pointer == AW'(i));
    vlb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .victim    (victim[i]),
      .insert    (insert),
      .chain_in  (links[i]),
      .chain_out (links[i+1])
    );
  end

  // Advance the replacement pointer on each new address
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_pointer <= '0;
    end else if (insert) begin
      replace_pointer <= (replace_pointer == LAST) ? '0 : replace_pointer + 1'b1;
    end
  end

  // Resolve the forwarding decision from the token at the chain tail
  always_comb begin
    logic       bcast;
    logic       self_dst;
    logic       hit;
    logic [1:0] op;
    logic [3:0] egress;
    bcast    = (key.dst == '1);
    self_dst = (key.dst == key.src);
    hit      = !bcast && (self_dst || (links[TABLE_ENTRIES].dst_hit &&
               !(links[TABLE_ENTRIES].dst_victim && !links[TABLE_ENTRIES].src_hit)));
    op       = self_dst ? key.port : links[TABLE_ENTRIES].dst_port;
    egress   = '0;
    done_word.verdict = VERDICT_FLOOD;
    if (hit) begin
      if (op == key.port) begin
        done_word.verdict = VERDICT_FILTER;
      end else begin
        done_word.verdict = VERDICT_UNICAST;
        if ({1'b0, op} < NP3 && link_up_mask[op]) begin
          egress[op] = 1'b1;
        end
      end
    end else begin
      for (int q = 0; q < NP; q++) begin
        if (2'(q) != key.port && link_up_mask[q] &&
            (trunk_port_mask[q] || access_vlans[12*q +: 12] == key.vlan)) begin
          egress[q] = 1'b1;
        end
      end
    end
    done_word.egress_mask = egress;
    done_word.tagged_mask = egress & trunk_port_mask;
    done_word.egress_vlan = key.vlan;
  end

  always_comb begin
    drop_word = '0;
    drop_word.verdict = VERDICT_DROP;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (class_vlan == '0) ? ST_OUT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (links[TABLE_ENTRIES].active) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    insert    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SEARCH: begin
        insert = links[TABLE_ENTRIES].active && !links[TABLE_ENTRIES].src_hit;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (take && class_vlan == '0) begin
      result <= drop_word;
    end else if (state == ST_SEARCH && links[TABLE_ENTRIES].active) begin
      result <= done_word;
    end
  end

  assign out_data = result;

endmodule
`default_nettype wire

### sv/vlb_cell.sv
// One address table entry with its compare logic and chain stage
`default_nettype none
module vlb_cell import vlb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire key_t   key,
  input  wire logic   victim,
  input  wire logic   insert,
  input  wire chain_t chain_in,
  output chain_t      chain_out
);

  logic              valid;
  logic [VLAN_W-1:0] vlan;
  logic [MAC_W-1:0]  mac;
  logic [1:0]        port;
  logic              src_match;
  logic              dst_match;

  assign src_match = valid && (vlan == key.vlan) && (mac == key.src);
  assign dst_match = valid && (vlan == key.vlan) && (mac == key.dst);

  // Hold the entry; refresh port on a source hit, overwrite on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (insert && victim) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (insert && victim) begin
      vlan <= key.vlan;
      mac  <= key.src;
      port <= key.port;
    end else if (chain_in.active && src_match) begin
      port <= key.port;
    end
  end

  // Advance the token one cell, folding in this entry's matches
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out <= '0;
    end else begin
      chain_out.active     <= chain_in.active;
      chain_out.src_hit    <= chain_in.src_hit | (chain_in.active & src_match);
      chain_out.dst_hit    <= chain_in.dst_hit | (chain_in.active & dst_match);
      chain_out.dst_victim <= chain_in.dst_victim | (chain_in.active & dst_match & victim);
      chain_out.dst_port   <= (chain_in.active && dst_match) ? port : chain_in.dst_port;
    end
  end

endmodule
`default_nettype wire

### sv/vlb_checker.sv
// Port-level checker for the VLAN learning bridge, bound to the top level
`default_nettype none
`include "vlan_learning_bridge_assert.svh"
module vlb_checker import vlb_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_word_t   out_data
);

  `VLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `VLB_ASSERT_IMP(a_one_in_flight, in_valid && in_ready, !out_valid, "word taken while a result is pending")
  `VLB_ASSERT_IMP(a_drop_empty, out_valid && out_data.verdict == VERDICT_DROP, out_data.egress_mask == 4'h0 && out_data.egress_vlan == 12'h0, "dropped word carries ports or VLAN")
  `VLB_ASSERT_IMP(a_tag_subset, out_valid, (out_data.tagged_mask & ~out_data.egress_mask) == 4'h0 && (out_data.verdict != VERDICT_FILTER || out_data.egress_mask == 4'h0), "tagged ports outside egress set")

endmodule

bind vlan_learning_bridge vlb_checker u_vlb_checker (.*);
`default_nettype wire
